/* rtl/core/bfrs_pkg.sv */
// Package for the bitmap fill run segmenter: field widths, constants,
// register index codes, sequencer states and the result record.
// No dependencies; every other file of the block imports it.
package bfrs_pkg;

    // Widths of the external fields.
    localparam int INDEX_BITS     = 16;
    localparam int COUNT_BITS     = 16;
    localparam int BIN_BITS       = 12;
    localparam int FILL_BITS      = 7;
    localparam int SHADE_BITS     = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Widths of the internal arithmetic.
    localparam int POS1_BITS      = INDEX_BITS + 1;   // piece position plus one
    localparam int START_BITS     = 28;               // start numerator
    localparam int END_BITS       = 29;               // end numerator
    localparam int PROD_BITS      = 28;               // (position+1) * bin count
    localparam int QUOT_BITS      = 28;               // bin bound quotients
    localparam int DEN_BITS       = 29;               // divisor and remainder
    localparam int NUM_BITS       = 29;               // fill numerator
    localparam int SCALED_BITS    = 24;               // count times twice full scale
    localparam int FILL_QUOT_BITS = 7;                // fill quotient before clamping
    localparam int ITER_BITS      = 5;

    // Fill scale.
    localparam int FULL_PERCENT   = 100;
    localparam int FILL_SCALE     = 2 * FULL_PERCENT;

    // Shade codes.
    localparam logic [SHADE_BITS-1:0] SHADE_FULL = 2'd0;
    localparam logic [SHADE_BITS-1:0] SHADE_HIGH = 2'd1;
    localparam logic [SHADE_BITS-1:0] SHADE_LOW  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PIECE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BIN_TOTAL   = 2'd1;

    // Per-item sequencer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_TEST,
        ST_DIV_E,
        ST_DIV_S,
        ST_SCALE,
        ST_DIV_F,
        ST_EMIT
    } state_t;

    // One run as it leaves the block.
    typedef struct packed {
        logic [INDEX_BITS-1:0] first;
        logic [INDEX_BITS-1:0] last;
        logic [FILL_BITS-1:0]  fill;
        logic [SHADE_BITS-1:0] shade;
        logic                  map_end;
        logic                  last_of_burst;
    } result_t;

    // Three-level shade of a fill value.
    function automatic logic [SHADE_BITS-1:0] shade_of(input logic [FILL_BITS-1:0] fill);
        logic [FILL_BITS:0] twice;
        twice = {fill, 1'b0};
        if (fill >= FILL_BITS'(FULL_PERCENT))
            return SHADE_FULL;
        else if (twice >= (FILL_BITS + 1)'(FULL_PERCENT))
            return SHADE_HIGH;
        else
            return SHADE_LOW;
    endfunction

endpackage

/* rtl/core/bitmap_fill_run_segmenter_unit.sv */
// Top level of the bitmap fill run segmenter: sequencer, bit-serial
// multiplier and divider, run merging and a two-entry result queue.
// Depends on bfrs_pkg.

// The block takes one bitmap bit per input transfer and turns each map of
// piece_count bits into runs of equal fill over the configured number of bins
// (register index 1). In pixel mode (piece_count below the bin count) an item
// goes from idle straight to emit. In bin mode it first passes through the
// bit-serial multiplier, which steps through the bin count (1 to 12 bits long)
// to form (position + 1) * bin count, then the bin test. An item that
// closes a bin holding set bits then uses a shared divider that retires one
// quotient bit per cycle to compute the two bin bounds and the fill; the fill
// division is skipped when the fill saturates. Up to two runs per item wait in
// a two-entry queue, so the next item is accepted while results are still
// pending; an item stalls only when the queue lacks room for its results.
// Registers may be written between items and take effect on the next item.
module bitmap_fill_run_segmenter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bfrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bfrs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                piece_done,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bfrs_pkg::INDEX_BITS-1:0]     run_first,
    output logic [bfrs_pkg::INDEX_BITS-1:0]     run_last,
    output logic [bfrs_pkg::FILL_BITS-1:0]      fill_percent,
    output logic [bfrs_pkg::SHADE_BITS-1:0]     shade,
    output logic                                map_end,
    output logic                                last_of_burst
);
    import bfrs_pkg::*;

    // Configuration and architectural state.
    logic [COUNT_BITS-1:0] piece_count_reg;
    logic [BIN_BITS-1:0]   bin_total_reg;
    logic [INDEX_BITS-1:0] piece_pos_reg;
    logic [BIN_BITS-1:0]   bin_pos_reg;
    logic [START_BITS-1:0] start_num_reg;
    logic [END_BITS-1:0]   end_num_reg;
    logic [COUNT_BITS-1:0] cnt_cur_reg;
    logic [COUNT_BITS-1:0] cnt_next_reg;
    logic                  run_open_reg;
    logic [INDEX_BITS-1:0] open_first_reg;
    logic [INDEX_BITS-1:0] open_last_reg;
    logic [FILL_BITS-1:0]  open_fill_reg;
    state_t                state_reg;
    state_t                state_next;

    // Per-item working registers.
    logic                  bit_reg;
    logic                  take_reg;
    logic                  close_reg;
    logic [FILL_BITS-1:0]  fill_reg;
    logic [PROD_BITS-1:0]  mcand_reg;
    logic [BIN_BITS-1:0]   mplier_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [DEN_BITS-1:0]   div_rem_reg;
    logic [QUOT_BITS-1:0]  div_dvd_reg;
    logic [DEN_BITS-1:0]   div_dsr_reg;
    logic [ITER_BITS-1:0]  iter_reg;
    logic [QUOT_BITS-1:0]  e_reg;

    // Result queue.
    result_t               q0_reg;
    result_t               q1_reg;
    result_t               q0_next;
    result_t               q1_next;
    logic [1:0]            q_cnt_reg;
    logic [1:0]            q_cnt_next;

    // Derived values.
    logic [BIN_BITS-1:0]   w_eff;
    logic                  pixel_mode;
    logic [POS1_BITS-1:0]  pos1;
    logic                  last_bit;
    logic                  map_start;
    logic                  in_fire;
    logic                  out_fire;
    logic                  mul_done;

    // Bin window test.
    logic [END_BITS-1:0]   pw2;
    logic                  fits_cur;
    logic                  hits_next;
    logic                  bin_ends;
    logic                  close_now;
    logic [COUNT_BITS-1:0] cnt_cur_inc;
    logic [COUNT_BITS-1:0] cnt_next_inc;
    logic [START_BITS-1:0] s_num;

    // Divider step.
    logic [DEN_BITS:0]     div_trial;
    logic [DEN_BITS:0]     div_diff;
    logic                  div_ge;
    logic [DEN_BITS-1:0]   div_rem_step;
    logic [QUOT_BITS-1:0]  div_dvd_step;
    logic                  div_last;

    // Fill scaling.
    logic [QUOT_BITS-1:0]      bin_len;
    logic [SCALED_BITS-1:0]    scaled;
    logic [NUM_BITS-1:0]       fill_num;
    logic [DEN_BITS-1:0]       fill_den;
    logic                      fill_sat;
    logic [FILL_QUOT_BITS-1:0] fill_q;
    logic [FILL_BITS-1:0]      fill_clamped;

    // Run merging.
    logic [INDEX_BITS-1:0] take_idx;
    logic                  extend;
    logic                  emit_a;
    logic                  emit_b;
    logic [INDEX_BITS-1:0] first_after;
    logic [INDEX_BITS-1:0] last_after;
    logic [FILL_BITS-1:0]  fill_after;
    logic                  open_after;
    logic [1:0]            n_res;
    logic                  room;
    logic                  emit_go;
    result_t               res_old;
    result_t               res_end;
    result_t               res0;

    // Control outputs of the sequencer.
    logic                  ready_ctl;

    assign cfg_ready = 1'b1;
    assign in_ready  = ready_ctl;
    assign in_fire   = in_valid && ready_ctl;
    assign out_valid = (q_cnt_reg != 2'd0);
    assign out_fire  = out_valid && out_ready;

    assign run_first     = q0_reg.first;
    assign run_last      = q0_reg.last;
    assign fill_percent  = q0_reg.fill;
    assign shade         = q0_reg.shade;
    assign map_end       = q0_reg.map_end;
    assign last_of_burst = q0_reg.last_of_burst;

    // Effective register values and map position.
    always_comb
    begin
        w_eff      = (bin_total_reg == '0) ? BIN_BITS'(1) : bin_total_reg;
        pixel_mode = piece_count_reg < COUNT_BITS'(w_eff);
        pos1       = POS1_BITS'(piece_pos_reg) + POS1_BITS'(1);
        last_bit   = pos1 >= POS1_BITS'(piece_count_reg);
        map_start  = (piece_pos_reg == '0);
        mul_done   = (mplier_reg[BIN_BITS-1:1] == '0);
    end

    // Which bins the current bit falls in, and whether the bin closes.
    always_comb
    begin
        pw2       = {prod_reg, 1'b0};
        fits_cur  = pw2 <= end_num_reg;
        hits_next = start_num_reg < prod_reg;
        bin_ends  = ({1'b0, end_num_reg} <
                     ({1'b0, pw2} + (END_BITS + 1)'({w_eff, 1'b0})));
        close_now = bin_ends || last_bit;
        cnt_cur_inc  = cnt_cur_reg;
        cnt_next_inc = cnt_next_reg;
        if (bit_reg && fits_cur && (cnt_cur_reg != '1))
            cnt_cur_inc = cnt_cur_reg + COUNT_BITS'(1);
        if (bit_reg && hits_next && (cnt_next_reg != '1))
            cnt_next_inc = cnt_next_reg + COUNT_BITS'(1);
        if (start_num_reg >= START_BITS'(piece_count_reg))
            s_num = start_num_reg - START_BITS'(piece_count_reg);
        else
            s_num = '0;
    end

    // One restoring division step: one quotient bit per cycle.
    always_comb
    begin
        div_trial    = {div_rem_reg, div_dvd_reg[QUOT_BITS-1]};
        div_diff     = div_trial - {1'b0, div_dsr_reg};
        div_ge       = div_trial >= {1'b0, div_dsr_reg};
        div_rem_step = div_ge ? div_diff[DEN_BITS-1:0] : div_trial[DEN_BITS-1:0];
        div_dvd_step = {div_dvd_reg[QUOT_BITS-2:0], div_ge};
        div_last     = (iter_reg == '0);
    end

    // Bin length and the rounded fill numerator and denominator.
    always_comb
    begin
        if (e_reg > div_dvd_reg)
            bin_len = e_reg - div_dvd_reg;
        else
            bin_len = QUOT_BITS'(1);
        scaled   = SCALED_BITS'(cnt_cur_reg) * SCALED_BITS'(FILL_SCALE);
        fill_num = NUM_BITS'(scaled) + NUM_BITS'(bin_len);
        fill_den = {bin_len, 1'b0};
        fill_sat = ({7'b0, fill_num} >= {fill_den, 7'b0});
        fill_q   = div_dvd_step[FILL_QUOT_BITS-1:0];
        if (fill_q > FILL_QUOT_BITS'(FULL_PERCENT))
            fill_clamped = FILL_BITS'(FULL_PERCENT);
        else
            fill_clamped = FILL_BITS'(fill_q);
    end

    // Run merging and the results of the item.
    always_comb
    begin
        take_idx = pixel_mode ? piece_pos_reg : INDEX_BITS'(bin_pos_reg);
        extend   = run_open_reg && ((open_last_reg + INDEX_BITS'(1)) == take_idx) &&
                   (open_fill_reg == fill_reg);
        emit_a   = take_reg && run_open_reg && !extend;
        first_after = open_first_reg;
        last_after  = open_last_reg;
        fill_after  = open_fill_reg;
        open_after  = run_open_reg;
        if (take_reg)
        begin
            if (extend)
            begin
                last_after = take_idx;
            end
            else
            begin
                first_after = take_idx;
                last_after  = take_idx;
                fill_after  = fill_reg;
                open_after  = 1'b1;
            end
        end
        emit_b = last_bit && open_after;
        n_res  = 2'(emit_a) + 2'(emit_b);
        room   = ({1'b0, q_cnt_reg} + {1'b0, n_res}) <= 3'd2;

        res_old.first         = open_first_reg;
        res_old.last          = open_last_reg;
        res_old.fill          = open_fill_reg;
        res_old.shade         = shade_of(open_fill_reg);
        res_old.map_end       = 1'b0;
        res_old.last_of_burst = !emit_b;

        res_end.first         = first_after;
        res_end.last          = last_after;
        res_end.fill          = fill_after;
        res_end.shade         = shade_of(fill_after);
        res_end.map_end       = 1'b1;
        res_end.last_of_burst = 1'b1;

        res0 = emit_a ? res_old : res_end;
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = pixel_mode ? ST_EMIT : ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                    state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (close_now && (cnt_cur_inc != '0))
                    state_next = ST_DIV_E;
                else
                    state_next = ST_EMIT;
            end
            ST_DIV_E:
            begin
                if (div_last)
                    state_next = ST_DIV_S;
            end
            ST_DIV_S:
            begin
                if (div_last)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = fill_sat ? ST_EMIT : ST_DIV_F;
            end
            ST_DIV_F:
            begin
                if (div_last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (room)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        ready_ctl = 1'b0;
        emit_go   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ready_ctl = 1'b1;
            end
            ST_EMIT:
            begin
                emit_go = room;
            end
            default:
            begin
                ready_ctl = 1'b0;
                emit_go   = 1'b0;
            end
        endcase
    end

    // Result queue: pop the head on a transfer, append new results behind.
    always_comb
    begin
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        q_cnt_next = q_cnt_reg;
        if (out_fire)
        begin
            q0_next    = q1_reg;
            q_cnt_next = q_cnt_reg - 2'd1;
        end
        if (emit_go && (emit_a || emit_b))
        begin
            if (q_cnt_next == 2'd0)
            begin
                q0_next = res0;
                q1_next = res_end;
            end
            else
            begin
                q1_next = res0;
            end
            q_cnt_next = q_cnt_next + n_res;
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            piece_count_reg <= COUNT_BITS'(1);
            bin_total_reg   <= BIN_BITS'(1);
            piece_pos_reg   <= '0;
            bin_pos_reg     <= '0;
            start_num_reg   <= '0;
            end_num_reg     <= '0;
            cnt_cur_reg     <= '0;
            cnt_next_reg    <= '0;
            run_open_reg    <= 1'b0;
            open_first_reg  <= '0;
            open_last_reg   <= '0;
            open_fill_reg   <= '0;
            q_cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            q_cnt_reg <= q_cnt_next;

            // Register writes.
            if (cfg_valid)
            begin
                if (cfg_index == CFG_PIECE_COUNT)
                    piece_count_reg <= cfg_data;
                else if (cfg_index == CFG_BIN_TOTAL)
                    bin_total_reg <= cfg_data[BIN_BITS-1:0];
            end

            // Bin state is loaded at the first bit of a map.
            if (in_fire && map_start)
            begin
                bin_pos_reg   <= '0;
                start_num_reg <= START_BITS'(piece_count_reg);
                end_num_reg   <= END_BITS'({piece_count_reg, 1'b0}) + END_BITS'(w_eff);
                cnt_cur_reg   <= '0;
                cnt_next_reg  <= '0;
            end

            // Count the bit into the bins that cover it.
            if (state_reg == ST_TEST)
            begin
                cnt_cur_reg  <= cnt_cur_inc;
                cnt_next_reg <= cnt_next_inc;
            end

            // Commit the item: runs, bin advance and map position.
            if (emit_go)
            begin
                run_open_reg   <= open_after && !last_bit;
                open_first_reg <= first_after;
                open_last_reg  <= last_after;
                open_fill_reg  <= fill_after;
                if (!pixel_mode && close_reg)
                begin
                    cnt_cur_reg   <= cnt_next_reg;
                    cnt_next_reg  <= '0;
                    bin_pos_reg   <= bin_pos_reg + BIN_BITS'(1);
                    start_num_reg <= start_num_reg + START_BITS'(piece_count_reg);
                    end_num_reg   <= end_num_reg + END_BITS'({piece_count_reg, 1'b0});
                end
                if (last_bit)
                    piece_pos_reg <= '0;
                else
                    piece_pos_reg <= pos1[INDEX_BITS-1:0];
            end
        end
    end

    // Queue payload.
    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    // Working registers of the multiplier, divider and fill path.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                bit_reg    <= piece_done;
                take_reg   <= piece_done;
                close_reg  <= 1'b0;
                fill_reg   <= FILL_BITS'(FULL_PERCENT);
                mcand_reg  <= PROD_BITS'(pos1);
                mplier_reg <= w_eff;
                prod_reg   <= '0;
            end
            ST_MUL:
            begin
                if (mplier_reg[0])
                    prod_reg <= prod_reg + mcand_reg;
                mcand_reg  <= {mcand_reg[PROD_BITS-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[BIN_BITS-1:1]};
            end
            ST_TEST:
            begin
                close_reg   <= close_now;
                take_reg    <= close_now && (cnt_cur_inc != '0);
                div_rem_reg <= '0;
                div_dvd_reg <= end_num_reg[END_BITS-1:1];
                div_dsr_reg <= DEN_BITS'(w_eff);
                iter_reg    <= ITER_BITS'(QUOT_BITS - 1);
            end
            ST_DIV_E:
            begin
                iter_reg <= iter_reg - ITER_BITS'(1);
                if (div_last)
                begin
                    e_reg       <= div_dvd_step;
                    div_rem_reg <= '0;
                    div_dvd_reg <= s_num;
                    iter_reg    <= ITER_BITS'(QUOT_BITS - 1);
                end
                else
                begin
                    div_rem_reg <= div_rem_step;
                    div_dvd_reg <= div_dvd_step;
                end
            end
            ST_DIV_S:
            begin
                iter_reg    <= iter_reg - ITER_BITS'(1);
                div_rem_reg <= div_rem_step;
                div_dvd_reg <= div_dvd_step;
            end
            ST_SCALE:
            begin
                fill_reg    <= FILL_BITS'(FULL_PERCENT);
                div_rem_reg <= DEN_BITS'(fill_num >> FILL_QUOT_BITS);
                div_dvd_reg <= {fill_num[FILL_QUOT_BITS-1:0],
                                (QUOT_BITS - FILL_QUOT_BITS)'(0)};
                div_dsr_reg <= fill_den;
                iter_reg    <= ITER_BITS'(FILL_QUOT_BITS - 1);
            end
            ST_DIV_F:
            begin
                iter_reg    <= iter_reg - ITER_BITS'(1);
                div_rem_reg <= div_rem_step;
                div_dvd_reg <= div_dvd_step;
                if (div_last)
                    fill_reg <= fill_clamped;
            end
            default:
            begin
                iter_reg <= iter_reg;
            end
        endcase
    end

endmodule

/* rtl/core/bfrs_checker.sv */
// Port-level checks for the bitmap fill run segmenter, bound to its top level.
// Depends on bfrs_pkg and on the port names of bitmap_fill_run_segmenter_unit.
module bfrs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [bfrs_pkg::INDEX_BITS-1:0] run_first,
    input logic [bfrs_pkg::INDEX_BITS-1:0] run_last,
    input logic [bfrs_pkg::FILL_BITS-1:0]  fill_percent,
    input logic [bfrs_pkg::SHADE_BITS-1:0] shade,
    input logic                            map_end,
    input logic                            last_of_burst
);
    import bfrs_pkg::*;

    // An item keeps the sequencer busy in the cycle after its transfer.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted in the cycle right after a transfer");

    // A stalled result holds its payload.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(run_first) &&
        $stable(run_last) && $stable(fill_percent) && $stable(shade) &&
        $stable(map_end) && $stable(last_of_burst))
        else $error("stalled result changed or dropped");

    // Shade follows the fill, and the fill never exceeds full scale.
    a_shade_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> shade == shade_of(fill_percent) &&
        fill_percent <= FILL_BITS'(FULL_PERCENT))
        else $error("shade does not match fill, or fill out of range");

    // The closing run of a map is always the last result of its item.
    a_map_end_closes_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && map_end |-> last_of_burst)
        else $error("map end run is not last of its burst");

    // Runs only grow upward.
    a_run_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> run_first <= run_last)
        else $error("run first index above run last index");

endmodule

bind bitmap_fill_run_segmenter_unit bfrs_checker u_bfrs_checker (.*);
